>>> rtl/core/bllca_pkg.sv
// Shared types, constants and helpers for the binary lifting LCA engine.
// Depends on nothing; bllca_ctrl and the top level use it, bllca_ram does not.
package bllca_pkg;

  localparam int unsigned NODES    = 1024;
  localparam int unsigned LEVELS   = 10;
  localparam int unsigned FIELD_W  = 10;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned NODE_W   = $clog2(NODES);
  localparam int unsigned LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned JT_DEPTH = LEVELS * NODES;
  localparam int unsigned JT_AW    = $clog2(JT_DEPTH);

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [LEVELS-1:0]  bits_t;
  typedef logic [JT_AW-1:0]   jaddr_t;
  typedef logic [KIND_W-1:0]  kind_t;

  localparam kind_t K_LOAD  = 2'd0;
  localparam kind_t K_BUILD = 2'd1;
  localparam kind_t K_LCA   = 2'd2;
  localparam kind_t K_KTH   = 2'd3;

  localparam logic ANS_LCA = 1'b0;
  localparam logic ANS_KTH = 1'b1;

  localparam lvl_t  LVL_LAST  = lvl_t'(LEVELS - 1);
  localparam node_t NODE_LAST = node_t'(NODES - 1);

  typedef struct packed {
    kind_t  kind;
    node_t  node_a;
    node_t  node_b;
    node_t  parent_node;
    field_t node_level;
    field_t steps;
  } item_t;

  typedef struct packed {
    node_t answer_node;
    logic  answer_kind;
  } res_t;

  // jump table port: one write, two reads
  typedef struct packed {
    logic   we;
    jaddr_t waddr;
    node_t  wdata;
    jaddr_t raddr_a;
    jaddr_t raddr_b;
  } jt_req_t;

  typedef struct packed {
    logic   we;
    node_t  waddr;
    field_t wdata;
    node_t  raddr_a;
    node_t  raddr_b;
  } dp_req_t;

  // table is laid out level-major: entry (level, node)
  function automatic jaddr_t jt_addr(input lvl_t lvl, input node_t node);
    jt_addr = jaddr_t'({lvl, node});
  endfunction

endpackage

>>> rtl/core/bllca_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// Standalone; used for the jump table and the depth store.
module bllca_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/core/bllca_ctrl.sv
// Sequencer for the LCA engine: load, pipelined table build and both queries.
// Depends on bllca_pkg; drives the jump table and depth RAMs in the top level.
module bllca_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bllca_pkg::item_t   in_item,
  output logic               res_valid,
  input  logic               res_ready,
  output bllca_pkg::res_t    res,
  output bllca_pkg::jt_req_t jt_req,
  input  bllca_pkg::node_t   jt_rd_a,
  input  bllca_pkg::node_t   jt_rd_b,
  output bllca_pkg::dp_req_t dp_req,
  input  bllca_pkg::field_t  dp_rd_a,
  input  bllca_pkg::field_t  dp_rd_b
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_BUILD  = 11'b000_0000_0010,
    S_BDRAIN = 11'b000_0000_0100,
    S_DCMP   = 11'b000_0000_1000,
    S_CLIMB  = 11'b000_0001_0000,
    S_CWAIT  = 11'b000_0010_0000,
    S_LIFT   = 11'b000_0100_0000,
    S_LCMP   = 11'b000_1000_0000,
    S_FINAL  = 11'b001_0000_0000,
    S_FWAIT  = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  bllca_pkg::lvl_t    k_r, k_nxt;
  bllca_pkg::node_t   x_r, x_nxt;
  bllca_pkg::node_t   y_r, y_nxt;
  bllca_pkg::bits_t   cnt_r, cnt_nxt;
  logic               kth_r, kth_nxt;
  bllca_pkg::node_t   i_r, i_nxt;
  // build pipeline: stage 1 holds the level k-1 entry, stage 2 the jumped one
  logic               v1_r, v1_nxt;
  logic               v2_r, v2_nxt;
  bllca_pkg::node_t   i1_r, i2_r;
  logic               load_acc;

  assign load_acc = (state_r == S_IDLE) && in_valid && (in_item.kind == bllca_pkg::K_LOAD);
  assign v1_nxt   = (state_r == S_BUILD);
  assign v2_nxt   = v1_r;

  always_comb begin
    dp_req.we      = load_acc;
    dp_req.waddr   = in_item.node_a;
    dp_req.wdata   = in_item.node_level;
    dp_req.raddr_a = in_item.node_a;
    dp_req.raddr_b = in_item.node_b;

    jt_req.we      = load_acc || v2_r;
    jt_req.waddr   = v2_r ? bllca_pkg::jt_addr(k_r, i2_r)
                          : bllca_pkg::jt_addr('0, in_item.node_a);
    jt_req.wdata   = v2_r ? jt_rd_b : in_item.parent_node;
    jt_req.raddr_a = bllca_pkg::jt_addr(k_r, x_r);
    jt_req.raddr_b = v1_r ? bllca_pkg::jt_addr(k_r - bllca_pkg::lvl_t'(1), jt_rd_a)
                          : bllca_pkg::jt_addr(k_r, y_r);
    if (state_r == S_BUILD) begin
      jt_req.raddr_a = bllca_pkg::jt_addr(k_r - bllca_pkg::lvl_t'(1), i_r);
    end else if (state_r == S_FINAL) begin
      jt_req.raddr_a = bllca_pkg::jt_addr('0, x_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    cnt_nxt   = cnt_r;
    kth_nxt   = kth_r;
    i_nxt     = i_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          x_nxt   = in_item.node_a;
          y_nxt   = in_item.node_b;
          k_nxt   = bllca_pkg::LVL_LAST;
          kth_nxt = (in_item.kind == bllca_pkg::K_KTH);
          cnt_nxt = bllca_pkg::bits_t'(in_item.steps);
          case (in_item.kind)
            bllca_pkg::K_LOAD: state_nxt = S_IDLE;
            bllca_pkg::K_BUILD: begin
              if (bllca_pkg::LEVELS > 1) begin
                k_nxt     = bllca_pkg::lvl_t'(1);
                i_nxt     = '0;
                state_nxt = S_BUILD;
              end
            end
            bllca_pkg::K_LCA: state_nxt = S_DCMP;
            default:          state_nxt = S_CLIMB;
          endcase
        end
      end
      S_BUILD: begin
        i_nxt = i_r + bllca_pkg::node_t'(1);
        if (i_r == bllca_pkg::NODE_LAST) begin
          state_nxt = S_BDRAIN;
        end
      end
      S_BDRAIN: begin
        // the last write of the level lands this edge; next level may read it
        if (!v1_r) begin
          if (k_r == bllca_pkg::LVL_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + bllca_pkg::lvl_t'(1);
            i_nxt     = '0;
            state_nxt = S_BUILD;
          end
        end
      end
      S_DCMP: begin
        if (dp_rd_a < dp_rd_b) begin
          x_nxt   = y_r;
          y_nxt   = x_r;
          cnt_nxt = bllca_pkg::bits_t'(dp_rd_b - dp_rd_a);
        end else begin
          cnt_nxt = bllca_pkg::bits_t'(dp_rd_a - dp_rd_b);
        end
        state_nxt = S_CLIMB;
      end
      S_CLIMB: begin
        if (cnt_r[k_r]) begin
          state_nxt = S_CWAIT;
        end else if (k_r != '0) begin
          k_nxt = k_r - bllca_pkg::lvl_t'(1);
        end else if (kth_r) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = bllca_pkg::LVL_LAST;
          state_nxt = S_LIFT;
        end
      end
      S_CWAIT: begin
        x_nxt = jt_rd_a;
        if (k_r != '0) begin
          k_nxt     = k_r - bllca_pkg::lvl_t'(1);
          state_nxt = S_CLIMB;
        end else if (kth_r) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = bllca_pkg::LVL_LAST;
          state_nxt = S_LIFT;
        end
      end
      S_LIFT: state_nxt = S_LCMP;
      S_LCMP: begin
        if (jt_rd_a != jt_rd_b) begin
          x_nxt = jt_rd_a;
          y_nxt = jt_rd_b;
        end
        if (k_r != '0) begin
          k_nxt     = k_r - bllca_pkg::lvl_t'(1);
          state_nxt = S_LIFT;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: state_nxt = (x_r != y_r) ? S_FWAIT : S_DONE;
      S_FWAIT: begin
        x_nxt     = jt_rd_a;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res.answer_node = x_r;
  assign res.answer_kind = kth_r ? bllca_pkg::ANS_KTH : bllca_pkg::ANS_LCA;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    cnt_r <= cnt_nxt;
    kth_r <= kth_nxt;
    i_r   <= i_nxt;
    i1_r  <= i_r;
    i2_r  <= i1_r;
  end

endmodule

>>> rtl/core/binary_lifting_lca_engine_unit.sv
// Binary lifting lowest common ancestor engine: top level.
// Usage:
//   One valid/ready input channel carries load, build and query beats; one
//   valid/ready output channel returns a beat for each query (kind 2 or 3).
//   Load beats write a node's parent and depth.
//   A build beat fills levels 1..LEVELS-1 of the jump table through a
//   three-stage read/read/write pipeline, one node per cycle, with a drain
//   state closing each level.
//   A kth ancestor query climbs the jump table; an LCA query runs a depth
//   compare, climb, lift and final parent step; each table step is a read
//   of the jump table RAM and a compare of its registered data.
//   Items are worked on one at a time; in_ready is high while the sequencer
//   waits for a beat.
//   Results sit in an output register, so the next item is taken while a
//   result waits; a stalled receiver holds the sequencer once its next
//   result is ready.
//   Reset (rst_n, synchronous) clears control state only; table and depth
//   contents stay undefined until loaded or built, and need no clearing.
// Depends on bllca_pkg, bllca_ram and bllca_ctrl.
module binary_lifting_lca_engine_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic [9:0]               in_node_a,
  input  logic [9:0]               in_node_b,
  input  logic [9:0]               in_parent_node,
  input  logic [9:0]               in_node_level,
  input  logic [9:0]               in_steps,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [9:0]               out_answer_node,
  output logic                     out_answer_kind
);

  bllca_pkg::item_t   item;
  bllca_pkg::res_t    res;
  logic               res_valid;
  logic               res_ready;
  bllca_pkg::jt_req_t jt_req;
  bllca_pkg::dp_req_t dp_req;
  bllca_pkg::node_t   jt_rd_a, jt_rd_b;
  bllca_pkg::field_t  dp_rd_a, dp_rd_b;

  logic               out_valid_r;
  bllca_pkg::field_t  out_node_r;
  logic               out_kind_r;

  // node numbers wrap modulo NODES
  assign item.kind        = in_kind;
  assign item.node_a      = bllca_pkg::node_t'(in_node_a);
  assign item.node_b      = bllca_pkg::node_t'(in_node_b);
  assign item.parent_node = bllca_pkg::node_t'(in_parent_node);
  assign item.node_level  = in_node_level;
  assign item.steps       = in_steps;

  bllca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .jt_req    (jt_req),
    .jt_rd_a   (jt_rd_a),
    .jt_rd_b   (jt_rd_b),
    .dp_req    (dp_req),
    .dp_rd_a   (dp_rd_a),
    .dp_rd_b   (dp_rd_b)
  );

  bllca_ram #(
    .WIDTH (bllca_pkg::NODE_W),
    .DEPTH (bllca_pkg::JT_DEPTH)
  ) u_jump_ram (
    .clk     (clk),
    .we      (jt_req.we),
    .waddr   (jt_req.waddr),
    .wdata   (jt_req.wdata),
    .raddr_a (jt_req.raddr_a),
    .raddr_b (jt_req.raddr_b),
    .rdata_a (jt_rd_a),
    .rdata_b (jt_rd_b)
  );

  bllca_ram #(
    .WIDTH (bllca_pkg::FIELD_W),
    .DEPTH (bllca_pkg::NODES)
  ) u_depth_ram (
    .clk     (clk),
    .we      (dp_req.we),
    .waddr   (dp_req.waddr),
    .wdata   (dp_req.wdata),
    .raddr_a (dp_req.raddr_a),
    .raddr_b (dp_req.raddr_b),
    .rdata_a (dp_rd_a),
    .rdata_b (dp_rd_b)
  );

  // output register: filled when empty or being emptied this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_node_r <= bllca_pkg::field_t'(res.answer_node);
      out_kind_r <= res.answer_kind;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_answer_node = out_node_r;
  assign out_answer_kind = out_kind_r;

`ifndef ASSERT_OFF
  a_res_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(!in_ready))
    else $error("result beat appeared while sequencer was idle");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == bllca_pkg::K_LOAD) |=> in_ready)
    else $error("load beat did not complete in one cycle");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("pending result lost or changed while output register full");
`endif

endmodule
